@@ rtl/hsl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hsl_pkg;

   // input pixel: hue in 1/16 degree, saturation and lightness in Q1.8
   typedef struct packed {
      logic signed [15:0] hue;
      logic [8:0]         saturation;
      logic [8:0]         lightness;
   } hsl_req_type;

   // output pixel, 8 bits per channel
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } hsl_rsp_type;

   // 1.0 in Q1.8
   localparam logic [8:0]  UNIT_Q8     = 9'd256;
   // one 60 degree sector in 1/16 degree
   localparam logic [9:0]  HUE_SECTOR  = 10'd960;
   // six full turns, makes any 16-bit hue non-negative
   localparam logic [17:0] HUE_BIAS    = 18'd34560;
   // floor(x / 15) == (x * RECIP_15) >> 15 for the ranges used here
   localparam logic [11:0] RECIP_15    = 12'd2185;
   // floor(x / 6) == (x * RECIP_6) >> 8 for x up to 70
   localparam logic [5:0]  RECIP_6     = 6'd43;
   // half of the channel scale 65536 * 960, added before the shift by 22 bits
   localparam logic [36:0] ROUND_HALF  = 37'd31457280;
   localparam logic [7:0]  BYTE_MAX    = 8'd255;

endpackage

`default_nettype wire

@@ rtl/hsl_to_rgb_converter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// HSL to RGB pixel converter. Takes one pixel per clock while req_ready is high and
// passes it through four pipeline register stages followed by the output register,
// each stage holding only small multipliers (at most 17 by 10 or 13 by 12 bits). Hue
// (signed, 1/16 degree) is wrapped modulo 360 degrees, saturation and lightness
// (Q1.8, 256 = 1.0) are clamped to 1.0, and each 8-bit channel is rounded half up.
// rsp_ready low holds every full stage that has no empty stage ahead of it, so
// bubbles still move up; req_ready falls only once every stage holds a pixel,
// so up to five pixels may be in flight.
module hsl_to_rgb_converter_unit (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  hsl_pkg::hsl_req_type req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output hsl_pkg::hsl_rsp_type rsp_data
);
   import hsl_pkg::*;

   // stage valid bits and advance enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic move1, move2, move3, move4, move_out;

   assign move_out  = !rsp_valid_ff || rsp_ready;
   assign move4     = !v4_ff || move_out;
   assign move3     = !v3_ff || move4;
   assign move2     = !v2_ff || move3;
   assign move1     = !v1_ff || move2;
   assign req_ready = move1;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (move1)    v1_ff        <= req_valid;
         if (move2)    v2_ff        <= v1_ff;
         if (move3)    v3_ff        <= v2_ff;
         if (move4)    v4_ff        <= v3_ff;
         if (move_out) rsp_valid_ff <= v4_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 1: hue bias and coarse divide by 960, clamp, 1 - |2L - 1|
   // ---------------------------------------------------------------
   logic [17:0] hue_biased;
   logic [10:0] hue_hi;
   logic [22:0] div15_prod;
   logic [8:0]  sat_clamp, light_clamp;
   logic [9:0]  light_x2;
   logic [9:0]  chroma_w;

   logic [6:0]  q1_in, q1_ff;
   logic [10:0] w1_in, w1_ff;
   logic [5:0]  lo1_in, lo1_ff;
   logic [8:0]  a1_in, a1_ff;
   logic [8:0]  s1_in, s1_ff;
   logic [8:0]  l1_in, l1_ff;

   always_comb begin
      // hue + 6 turns is in 1792..67327, and 5760 is a multiple of 960
      hue_biased  = {{2{req_data.hue[15]}}, req_data.hue} + HUE_BIAS;
      hue_hi      = hue_biased[16:6];
      div15_prod  = hue_hi * RECIP_15;
      sat_clamp   = (req_data.saturation > UNIT_Q8) ? UNIT_Q8 : req_data.saturation;
      light_clamp = (req_data.lightness > UNIT_Q8) ? UNIT_Q8 : req_data.lightness;
      light_x2    = {light_clamp, 1'b0};
      // 256 - |2L - 256|
      chroma_w    = (light_clamp[8] || light_clamp[7]) ? (10'd512 - light_x2) : light_x2;
      q1_in       = div15_prod[21:15];
      w1_in       = hue_hi;
      lo1_in      = hue_biased[5:0];
      a1_in       = chroma_w[8:0];
      s1_in       = sat_clamp;
      l1_in       = light_clamp;
   end

   always_ff @(posedge clock) begin
      if (move1) begin
         q1_ff  <= q1_in;
         w1_ff  <= w1_in;
         lo1_ff <= lo1_in;
         a1_ff  <= a1_in;
         s1_ff  <= s1_in;
         l1_ff  <= l1_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: sector and fraction, normalized chroma
   // ---------------------------------------------------------------
   logic [10:0] rem15;
   logic [12:0] div6_prod;
   logic [3:0]  q6;
   logic [6:0]  sector_full;
   logic [17:0] chroma_prod;

   logic [2:0]  sec2_in, sec2_ff;
   logic [9:0]  frac2_in, frac2_ff;
   logic [16:0] cn2_in, cn2_ff;
   logic [8:0]  l2_ff;

   always_comb begin
      rem15       = w1_ff - ((11'(q1_ff) << 4) - 11'(q1_ff));
      div6_prod   = q1_ff * RECIP_6;
      q6          = div6_prod[11:8];
      // sector is the sixty degree count modulo 6
      sector_full = q1_ff - ((7'(q6) << 2) + (7'(q6) << 1));
      chroma_prod = a1_ff * s1_ff;
      sec2_in     = sector_full[2:0];
      frac2_in    = {rem15[3:0], lo1_ff};
      cn2_in      = chroma_prod[16:0];
   end

   always_ff @(posedge clock) begin
      if (move2) begin
         sec2_ff  <= sec2_in;
         frac2_ff <= frac2_in;
         cn2_ff   <= cn2_in;
         l2_ff    <= l1_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: C, X and m on the scale 65536 * 960
   // ---------------------------------------------------------------
   logic [9:0]  frac_sel;
   logic [26:0] x_prod;
   logic [27:0] m_pos, m_neg;

   logic [25:0]        cval3_in, cval3_ff;
   logic [25:0]        xval3_in, xval3_ff;
   logic signed [27:0] mval3_in, mval3_ff;
   logic [2:0]         sec3_ff;

   always_comb begin
      // odd sectors run the secondary value downward
      frac_sel = sec2_ff[0] ? (HUE_SECTOR - frac2_ff) : frac2_ff;
      x_prod   = cn2_ff * frac_sel;
      // L * 245760 and Cn * 480 as shift pairs
      m_pos    = (28'(l2_ff) << 18) - (28'(l2_ff) << 14);
      m_neg    = (28'(cn2_ff) << 9) - (28'(cn2_ff) << 5);
      cval3_in = (26'(cn2_ff) << 10) - (26'(cn2_ff) << 6);
      xval3_in = x_prod[25:0];
      mval3_in = $signed(m_pos - m_neg);
   end

   always_ff @(posedge clock) begin
      if (move3) begin
         cval3_ff <= cval3_in;
         xval3_ff <= xval3_in;
         mval3_ff <= mval3_in;
         sec3_ff  <= sec2_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 4: channel order, add m, scale by 255 and drop 2^22
   // ---------------------------------------------------------------
   logic [25:0]        r_base, g_base, b_base;
   logic signed [27:0] r_val, g_val, b_val;
   logic signed [36:0] r_scaled, g_scaled, b_scaled;

   logic        rz4_in, gz4_in, bz4_in, rz4_ff, gz4_ff, bz4_ff;
   logic [12:0] ry4_in, gy4_in, by4_in, ry4_ff, gy4_ff, by4_ff;

   always_comb begin
      unique case (sec3_ff)
         3'd0: begin
            r_base = cval3_ff; g_base = xval3_ff; b_base = '0;
         end
         3'd1: begin
            r_base = xval3_ff; g_base = cval3_ff; b_base = '0;
         end
         3'd2: begin
            r_base = '0; g_base = cval3_ff; b_base = xval3_ff;
         end
         3'd3: begin
            r_base = '0; g_base = xval3_ff; b_base = cval3_ff;
         end
         3'd4: begin
            r_base = xval3_ff; g_base = '0; b_base = cval3_ff;
         end
         default: begin
            r_base = cval3_ff; g_base = '0; b_base = xval3_ff;
         end
      endcase
      r_val    = $signed({2'b00, r_base}) + mval3_ff;
      g_val    = $signed({2'b00, g_base}) + mval3_ff;
      b_val    = $signed({2'b00, b_base}) + mval3_ff;
      // v * 255 + half, then divide by 2^22 (the /15 follows)
      r_scaled = (37'(r_val) <<< 8) - 37'(r_val) + $signed(ROUND_HALF);
      g_scaled = (37'(g_val) <<< 8) - 37'(g_val) + $signed(ROUND_HALF);
      b_scaled = (37'(b_val) <<< 8) - 37'(b_val) + $signed(ROUND_HALF);
      rz4_in   = (r_val <= 28'sd0);
      gz4_in   = (g_val <= 28'sd0);
      bz4_in   = (b_val <= 28'sd0);
      ry4_in   = r_scaled[34:22];
      gy4_in   = g_scaled[34:22];
      by4_in   = b_scaled[34:22];
   end

   always_ff @(posedge clock) begin
      if (move4) begin
         rz4_ff <= rz4_in;
         gz4_ff <= gz4_in;
         bz4_ff <= bz4_in;
         ry4_ff <= ry4_in;
         gy4_ff <= gy4_in;
         by4_ff <= by4_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 5: divide by 15, clamp to a byte, output register
   // ---------------------------------------------------------------
   logic [24:0]  r_div, g_div, b_div;
   hsl_rsp_type  rsp_data_in, rsp_data_ff;

   always_comb begin
      r_div = ry4_ff * RECIP_15;
      g_div = gy4_ff * RECIP_15;
      b_div = by4_ff * RECIP_15;
      rsp_data_in.red   = rz4_ff ? 8'd0 :
                          ((r_div[24:15] > 10'(BYTE_MAX)) ? BYTE_MAX : r_div[22:15]);
      rsp_data_in.green = gz4_ff ? 8'd0 :
                          ((g_div[24:15] > 10'(BYTE_MAX)) ? BYTE_MAX : g_div[22:15]);
      rsp_data_in.blue  = bz4_ff ? 8'd0 :
                          ((b_div[24:15] > 10'(BYTE_MAX)) ? BYTE_MAX : b_div[22:15]);
   end

   always_ff @(posedge clock) begin
      if (move_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_data = rsp_data_ff;

`ifndef SYNTHESIS
   // input stalls only when every stage holds a pixel
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (v1_ff && v2_ff && v3_ff && v4_ff && rsp_valid_ff))
      else $error("input stalled with a bubble in the pipeline");

   // an input transfer always lands in stage 1
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff)
      else $error("input transfer lost at stage 1");

   // hue wrap yields a legal sector and fraction
   a_sector: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (sec2_ff <= 3'd5 && frac2_ff < HUE_SECTOR))
      else $error("hue sector or fraction out of range");
`endif

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import hsl_pkg::*;

   // scales of the conversion: full turn and sector in 1/16 degree, 1.0 in Q1.8
   localparam longint HUE_TURN     = 5760;
   localparam longint SECTOR_SPAN  = 960;
   localparam longint ONE_Q8       = 256;
   localparam longint CHANNEL_DEN  = 65536 * 960;
   localparam int     DIRECT_COUNT = 22;
   localparam int     RANDOM_COUNT = 1200;
   localparam int     HOLD_AT      = 400;
   localparam int     HOLD_CYCLES  = 150;
   localparam int     DRAIN_CYCLES = 12;
   localparam int     WATCHDOG_MAX = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   hsl_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   hsl_rsp_type rsp_data;

   hsl_req_type pending_pixels[$];
   hsl_rsp_type expected_rgb[$];

   logic req_taken = 1'b0;
   int   pixels_accepted = 0;
   int   pixels_checked = 0;
   int   mismatch_count = 0;
   int   quiet_cycles = 0;
   int   cycle_count = 0;
   int   send_gap = 0;
   int   stall_left = 0;
   int   hold_left = 0;
   int   hold_seen = 0;
   bit   hold_done = 1'b0;

   hsl_to_rgb_converter_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock generation
   always #4 clock = ~clock;

   // one 8-bit channel from its exact value, rounded half up and clamped
   function automatic logic [7:0] byte_from_channel(longint level);
      longint q;
      if (level <= 0) return 8'd0;
      q = (level * 255 + CHANNEL_DEN / 2) / CHANNEL_DEN;
      if (q > 255) q = 255;
      return q[7:0];
   endfunction

   // expected rgb pixel for one hsl pixel
   function automatic hsl_rsp_type rgb_from_hsl(hsl_req_type px);
      longint      hue_val, sat, lum, wrapped, sector, frac, light_gap;
      longint      chroma, c_full, x_full, offset, r, g, b;
      hsl_rsp_type rgb;
      hue_val = $signed(px.hue);
      sat = px.saturation;
      lum = px.lightness;
      if (sat > ONE_Q8) sat = ONE_Q8;
      if (lum > ONE_Q8) lum = ONE_Q8;
      wrapped = hue_val % HUE_TURN;
      if (wrapped < 0) wrapped = wrapped + HUE_TURN;
      sector = wrapped / SECTOR_SPAN;
      frac = wrapped % SECTOR_SPAN;
      light_gap = 2 * lum - ONE_Q8;
      if (light_gap < 0) light_gap = -light_gap;
      chroma = (ONE_Q8 - light_gap) * sat;
      c_full = chroma * SECTOR_SPAN;
      // secondary rises in even sectors and falls in odd ones
      if (sector % 2 == 0) x_full = chroma * frac;
      else x_full = chroma * (SECTOR_SPAN - frac);
      offset = lum * ONE_Q8 * SECTOR_SPAN - chroma * (SECTOR_SPAN / 2);
      case (sector)
         0: begin r = c_full; g = x_full; b = 0; end
         1: begin r = x_full; g = c_full; b = 0; end
         2: begin r = 0; g = c_full; b = x_full; end
         3: begin r = 0; g = x_full; b = c_full; end
         4: begin r = x_full; g = 0; b = c_full; end
         default: begin r = c_full; g = 0; b = x_full; end
      endcase
      rgb.red = byte_from_channel(r + offset);
      rgb.green = byte_from_channel(g + offset);
      rgb.blue = byte_from_channel(b + offset);
      return rgb;
   endfunction

   // one line per wrong or unexpected result
   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   // idle length: mostly none or short, now and then long
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // no idling on either side in every fourth window of the cycle count
   function automatic bit burst_window();
      return (cycle_count / 128) % 4 == 3;
   endfunction

   task automatic add_pixel(int hue, int sat, int lum);
      hsl_req_type px;
      px.hue = hue[15:0];
      px.saturation = sat[8:0];
      px.lightness = lum[8:0];
      pending_pixels.push_back(px);
   endtask

   function automatic int random_level();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 0;
      if (pick == 1) return 256;
      if (pick == 2) return $urandom_range(257, 511);
      return $urandom_range(0, 256);
   endfunction

   function automatic int random_hue();
      int pick;
      pick = $urandom_range(0, 3);
      if (pick < 2) return $urandom_range(0, 65535);
      // near a sector edge, anywhere in the signed 16-bit hue range
      if (pick == 2) return 960 * ($urandom_range(0, 68) - 34) + $urandom_range(0, 2) - 1;
      return $urandom_range(0, 5759);
   endfunction

   // accepted transfers on both channels, prediction, check and watchdog
   always @(posedge clock) begin : monitor
      hsl_rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_rgb.size() == 0) begin
               report_mismatch("unexpected pixel, red", rsp_data.red, 0);
            end else begin
               want = expected_rgb.pop_front();
               pixels_checked++;
               if (rsp_data.red !== want.red)
                  report_mismatch("red", rsp_data.red, want.red);
               if (rsp_data.green !== want.green)
                  report_mismatch("green", rsp_data.green, want.green);
               if (rsp_data.blue !== want.blue)
                  report_mismatch("blue", rsp_data.blue, want.blue);
            end
         end
         if (req_valid && req_ready) begin
            expected_rgb.push_back(rgb_from_hsl(req_data));
            pixels_accepted++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX) begin
               $display("watchdog: no transfer for %0d cycles", quiet_cycles);
               $display("CHECK FAILED");
               $finish;
            end
         end
      end
   end

   // input driver, keeps offering with no gaps around the output hold-off
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_pixels.size() > 0) begin
            req_data <= pending_pixels.pop_front();
            req_valid <= 1'b1;
            if (burst_window() || (pixels_accepted >= HOLD_AT && pixels_accepted < HOLD_AT + 20))
               send_gap = 0;
            else
               send_gap = idle_length();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // output side: random stalls plus one long hold-off to fill the pipeline
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         hold_seen++;
         rsp_ready <= 1'b0;
      end else if (!hold_done && pixels_accepted >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = burst_window() ? 0 : idle_length();
      end
   end

   // stimulus, reset and end of run
   initial begin
      // corners: hue extremes and wrap, sector edges, grey, black, white, clamped levels
      add_pixel(-32768, 256, 128);
      add_pixel(32767, 256, 128);
      add_pixel(0, 256, 128);
      add_pixel(959, 256, 128);
      add_pixel(960, 256, 128);
      add_pixel(1920, 256, 128);
      add_pixel(2880, 256, 128);
      add_pixel(3840, 256, 128);
      add_pixel(4800, 256, 128);
      add_pixel(5759, 256, 128);
      add_pixel(5760, 256, 128);
      add_pixel(-1, 256, 128);
      add_pixel(-960, 200, 100);
      add_pixel(1000, 0, 128);
      add_pixel(2000, 256, 0);
      add_pixel(3000, 256, 256);
      add_pixel(4000, 511, 511);
      add_pixel(480, 257, 300);
      add_pixel(480, 300, 128);
      add_pixel(1440, 256, 1);
      add_pixel(2400, 256, 255);
      add_pixel(3360, 128, 64);
      for (int i = 0; i < RANDOM_COUNT; i++)
         add_pixel(random_hue(), random_level(), random_level());

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (pixels_accepted == DIRECT_COUNT + RANDOM_COUNT);
      wait (expected_rgb.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rgb.size() != 0)
         report_mismatch("pixels never returned", 0, expected_rgb.size());

      $display("%0d pixels (%0d directed corners, %0d random) converted, %0d checked",
               pixels_accepted, DIRECT_COUNT, RANDOM_COUNT, pixels_checked);
      $display("output held off for %0d cycles with input pressure, %0d mismatches",
               hold_seen, mismatch_count);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
